FILE: sv/lfcd_pkg.sv
// ----------------------------------------------------------------------------
// lfcd_pkg
// shared constants, codes and types of the length framed checksum deframer
// ----------------------------------------------------------------------------
package lfcd_pkg;

	localparam int BUFFER_BYTES = 64;
	localparam int ADDR_W       = $clog2(BUFFER_BYTES);
	localparam int DATA_W       = 8;
	localparam int LEN_W        = 6;
	localparam int STATUS_W     = 2;
	localparam int CFG_IDX_W    = 1;

	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef logic [STATUS_W-1:0]  status_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam status_t ST_PAYLOAD = 2'd0;
	localparam status_t ST_EMPTY   = 2'd1;
	localparam status_t ST_BADLEN  = 2'd2;
	localparam status_t ST_BADSUM  = 2'd3;

	localparam cfg_idx_t CFG_SYNC   = 1'b0;
	localparam cfg_idx_t CFG_MAXLEN = 1'b1;

	localparam logic [DATA_W-1:0] SYNC_RESET   = 8'd97;
	localparam logic [LEN_W-1:0]  MAXLEN_RESET = 6'd63;

	// one finished frame handed from the receive side to the drain side
	typedef struct packed {
		status_t          status;
		logic [LEN_W-1:0] len;
	} job_t;

endpackage

FILE: sv/lfcd_if.sv
// ----------------------------------------------------------------------------
// lfcd channel interfaces
// receive byte channel, result channel and register write channel
// ----------------------------------------------------------------------------
interface lfcd_rx_if;
	logic                         valid;
	logic                         ready;
	logic [lfcd_pkg::DATA_W-1:0]  rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface lfcd_res_if;
	logic                         valid;
	logic                         ready;
	logic [lfcd_pkg::DATA_W-1:0]  payload_byte;
	logic [lfcd_pkg::LEN_W-1:0]   byte_index;
	logic                         last;
	lfcd_pkg::status_t            status;

	modport source (output valid, output payload_byte, output byte_index, output last,
		output status, input ready);
	modport sink (input valid, input payload_byte, input byte_index, input last,
		input status, output ready);
endinterface

interface lfcd_cfg_if;
	logic                         valid;
	logic                         ready;
	lfcd_pkg::cfg_idx_t           index;
	logic [lfcd_pkg::DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/lfcd_ram.sv
// ----------------------------------------------------------------------------
// lfcd_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lfcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: sv/lfcd_front.sv
// ----------------------------------------------------------------------------
// lfcd_front
// receive side: sync hunt, length check, payload store and checksum compare
// ----------------------------------------------------------------------------
module lfcd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	lfcd_rx_if.sink                       rx,
	lfcd_cfg_if.sink                      cfg,
	input  logic                          q_full,
	output logic                          push,
	output lfcd_pkg::job_t                push_job,
	input  logic                          drain_done,
	output logic                          wr_en,
	output logic [lfcd_pkg::ADDR_W-1:0]   wr_addr,
	output logic [lfcd_pkg::DATA_W-1:0]   wr_data
);

	typedef enum logic [3:0] {
		F_HUNT = 4'b0001,
		F_LEN  = 4'b0010,
		F_PAY  = 4'b0100,
		F_CHK  = 4'b1000
	} fstate_t;

	fstate_t                          state_q, state_d;
	logic [lfcd_pkg::DATA_W-1:0]      sync_q;
	logic [lfcd_pkg::LEN_W-1:0]       max_len_q;
	logic [lfcd_pkg::LEN_W-1:0]       len_q, len_d;
	logic [lfcd_pkg::LEN_W-1:0]       cnt_q, cnt_d, cnt_inc;
	logic [lfcd_pkg::DATA_W-1:0]      sum_q, sum_d, byte_sum;
	logic                             pend_q;
	logic                             take;
	logic                             len_bad;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q    <= lfcd_pkg::SYNC_RESET;
			max_len_q <= lfcd_pkg::MAXLEN_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				lfcd_pkg::CFG_SYNC:   sync_q    <= cfg.data;
				lfcd_pkg::CFG_MAXLEN: max_len_q <= cfg.data[lfcd_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// payload bytes wait while the store still holds a frame being drained
	assign rx.ready = !(((state_q == F_LEN) || (state_q == F_CHK)) && q_full) &&
		!((state_q == F_PAY) && pend_q);
	assign take     = rx.valid && rx.ready;
	assign byte_sum = sum_q + rx.rx_byte;
	assign cnt_inc  = cnt_q + 1'b1;
	assign len_bad  = (rx.rx_byte > {2'b00, max_len_q}) ||
		(rx.rx_byte >= lfcd_pkg::DATA_W'(lfcd_pkg::BUFFER_BYTES));

	assign wr_addr = cnt_q[lfcd_pkg::ADDR_W-1:0];
	assign wr_data = rx.rx_byte;

	always_comb begin
		state_d  = state_q;
		len_d    = len_q;
		cnt_d    = cnt_q;
		sum_d    = sum_q;
		push     = 1'b0;
		push_job = '0;
		wr_en    = 1'b0;
		if (take) begin
			case (state_q)
				F_HUNT: begin
					if (rx.rx_byte == sync_q) begin
						sum_d   = rx.rx_byte;
						cnt_d   = '0;
						state_d = F_LEN;
					end
				end
				F_LEN: begin
					if (len_bad) begin
						push            = 1'b1;
						push_job.status = lfcd_pkg::ST_BADLEN;
						state_d         = F_HUNT;
					end else begin
						len_d   = rx.rx_byte[lfcd_pkg::LEN_W-1:0];
						sum_d   = byte_sum;
						state_d = (rx.rx_byte[lfcd_pkg::LEN_W-1:0] == '0) ? F_CHK : F_PAY;
					end
				end
				F_PAY: begin
					wr_en = 1'b1;
					cnt_d = cnt_inc;
					sum_d = byte_sum;
					if (cnt_inc >= len_q) begin
						state_d = F_CHK;
					end
				end
				F_CHK: begin
					push         = 1'b1;
					push_job.len = len_q;
					if (sum_q != rx.rx_byte) begin
						push_job.status = lfcd_pkg::ST_BADSUM;
					end else if (len_q == '0) begin
						push_job.status = lfcd_pkg::ST_EMPTY;
					end else begin
						push_job.status = lfcd_pkg::ST_PAYLOAD;
					end
					state_d = F_HUNT;
				end
				default: state_d = F_HUNT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_HUNT;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push && (push_job.status == lfcd_pkg::ST_PAYLOAD)) begin
				pend_q <= 1'b1;
			end else if (drain_done) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		len_q <= len_d;
		cnt_q <= cnt_d;
		sum_q <= sum_d;
	end

endmodule

FILE: sv/lfcd_queue.sv
// ----------------------------------------------------------------------------
// lfcd_queue
// short job queue between the receive side and the drain side
// ----------------------------------------------------------------------------
module lfcd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lfcd_pkg::job_t  push_job,
	output logic            full,
	input  logic            pop,
	output lfcd_pkg::job_t  pop_job,
	output logic            empty
);

	lfcd_pkg::job_t                 mem_q [lfcd_pkg::QUEUE_DEPTH];
	logic [lfcd_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [lfcd_pkg::QCNT_W-1:0]    cnt_q;

	assign full    = (cnt_q == lfcd_pkg::QCNT_W'(lfcd_pkg::QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

FILE: sv/lfcd_back.sv
// ----------------------------------------------------------------------------
// lfcd_back
// drain side: turns queued jobs into status results or payload byte runs
// ----------------------------------------------------------------------------
module lfcd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          empty,
	input  lfcd_pkg::job_t                pop_job,
	output logic                          pop,
	output logic                          rd_en,
	output logic [lfcd_pkg::ADDR_W-1:0]   rd_addr,
	input  logic [lfcd_pkg::DATA_W-1:0]   rd_data,
	output logic                          drain_done,
	lfcd_res_if.source                    result
);

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_READ = 3'b010,
		B_SEND = 3'b100
	} bstate_t;

	bstate_t                        state_q, state_d;
	lfcd_pkg::status_t              status_q;
	logic [lfcd_pkg::LEN_W-1:0]     len_q;
	logic [lfcd_pkg::LEN_W-1:0]     idx_q;
	logic                           last_q;
	logic                           is_pay_q;
	logic                           is_pay;
	logic                           take;

	assign is_pay  = (pop_job.status == lfcd_pkg::ST_PAYLOAD);
	assign pop     = (state_q == B_IDLE) && !empty;
	assign rd_en   = (state_q == B_READ);
	assign rd_addr = idx_q[lfcd_pkg::ADDR_W-1:0];

	assign result.valid        = (state_q == B_SEND);
	assign result.payload_byte = is_pay_q ? rd_data : '0;
	assign result.byte_index   = idx_q;
	assign result.last         = last_q;
	assign result.status       = status_q;

	assign take       = result.valid && result.ready;
	assign drain_done = take && is_pay_q && last_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!empty) begin
					state_d = is_pay ? B_READ : B_SEND;
				end
			end
			B_READ: state_d = B_SEND;
			B_SEND: begin
				if (take) begin
					state_d = (is_pay_q && !last_q) ? B_READ : B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= pop_job.status;
			len_q    <= pop_job.len;
			idx_q    <= '0;
			is_pay_q <= is_pay;
			last_q   <= 1'b1;
		end else if (state_q == B_READ) begin
			last_q <= (idx_q == (len_q - 1'b1));
		end else if (take && is_pay_q && !last_q) begin
			idx_q <= idx_q + 1'b1;
		end
	end

endmodule

FILE: sv/length_framed_checksum_deframer_top.sv
// ----------------------------------------------------------------------------
// length_framed_checksum_deframer_top
// recovers sync, length, payload, checksum frames from a byte stream
// ----------------------------------------------------------------------------
// receive side takes one byte per cycle; length and checksum bytes wait while
// the job queue is full, payload bytes wait until the previous run is drained
// a status result is offered once its job is registered in the job queue and popped
// by the idle drain side; a payload result also waits for the registered store read
// each payload byte is read from the store, then sent; the next read waits for the take
// reset: hunting for sync, queue empty, sync 97 and max length 63; store not cleared
module length_framed_checksum_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	lfcd_rx_if.sink     rx,
	lfcd_cfg_if.sink    cfg,
	lfcd_res_if.source  result
);

	logic                           q_full, q_empty, push, pop;
	lfcd_pkg::job_t                 push_job, pop_job;
	logic                           drain_done;
	logic                           wr_en, rd_en;
	logic [lfcd_pkg::ADDR_W-1:0]    wr_addr, rd_addr;
	logic [lfcd_pkg::DATA_W-1:0]    wr_data, rd_data;

	lfcd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.cfg        (cfg),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job),
		.drain_done (drain_done),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	lfcd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	lfcd_ram #(
		.WIDTH (lfcd_pkg::DATA_W),
		.DEPTH (lfcd_pkg::BUFFER_BYTES)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	lfcd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (q_empty),
		.pop_job    (pop_job),
		.pop        (pop),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.drain_done (drain_done),
		.result     (result)
	);

endmodule

FILE: bench/length_framed_checksum_deframer_result_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deframer_result_check
// watches the receive, register and result channels of the deframer, keeps
// its own copy of the frame parser and the payload store, and compares every
// accepted result transaction field by field with the oldest expected one
// ----------------------------------------------------------------------------
module deframer_result_check (
	input  logic  clk,
	input  logic  arst_n,
	lfcd_rx_if    rx,
	lfcd_cfg_if   cfg,
	lfcd_res_if   result,
	output int    fails,
	output int    pending
);
	import lfcd_pkg::*;

	typedef enum logic [1:0] {
		PH_LEN    = 2'd0,
		PH_PAY    = 2'd1,
		PH_SUM    = 2'd2,
		PH_UNUSED = 2'd3
	} parse_phase_t;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [LEN_W-1:0]  idx;
		logic              last;
		status_t           status;
	} frame_result_t;

	logic [DATA_W-1:0] sync_val;
	logic [LEN_W-1:0]  max_len;
	logic              framing;
	parse_phase_t      ph;
	logic [LEN_W-1:0]  flen;
	logic [LEN_W-1:0]  rcv;
	logic [DATA_W-1:0] sum;
	logic [DATA_W-1:0] store [BUFFER_BYTES];
	frame_result_t     frame_results_q [$];

	function automatic void push_result(input logic [DATA_W-1:0] d, input logic [LEN_W-1:0] i,
			input logic l, input status_t s);
		frame_result_t r;
		r.data   = d;
		r.idx    = i;
		r.last   = l;
		r.status = s;
		frame_results_q.push_back(r);
	endfunction

	function automatic void take_byte(input logic [DATA_W-1:0] b);
		if (!framing) begin
			if (b == sync_val) begin
				framing = 1'b1;
				ph      = PH_LEN;
				rcv     = '0;
				sum     = b;
			end
		end else begin
			case (ph)
				PH_LEN: begin
					if (b > {2'b00, max_len} || int'(b) >= BUFFER_BYTES) begin
						framing = 1'b0;
						ph      = PH_LEN;
						push_result('0, '0, 1'b1, ST_BADLEN);
					end else begin
						flen = b[LEN_W-1:0];
						sum  = sum + b;
						ph   = (flen == 0) ? PH_SUM : PH_PAY;
					end
				end
				PH_PAY: begin
					store[rcv] = b;
					rcv        = rcv + 1'b1;
					sum        = sum + b;
					if (rcv >= flen)
						ph = PH_SUM;
				end
				PH_SUM: begin
					framing = 1'b0;
					ph      = PH_LEN;
					if (sum != b)
						push_result('0, '0, 1'b1, ST_BADSUM);
					else if (flen == 0)
						push_result('0, '0, 1'b1, ST_EMPTY);
					else
						for (int i = 0; i < int'(flen); i++)
							push_result(store[i], LEN_W'(i), (i + 1 == int'(flen)), ST_PAYLOAD);
				end
				default: begin
					framing = 1'b0;
					ph      = PH_LEN;
				end
			endcase
		end
	endfunction

	function automatic int check_result();
		frame_result_t want;
		int            errs;
		errs = 0;
		if (frame_results_q.size() == 0) begin
			$display("%0t: unexpected result payload_byte %0d byte_index %0d last %0d status %0d",
				$time, result.payload_byte, result.byte_index, result.last, result.status);
			return 1;
		end
		want = frame_results_q.pop_front();
		if (result.payload_byte !== want.data) begin
			$display("%0t: payload_byte expected %0d actual %0d", $time, want.data,
				result.payload_byte);
			errs++;
		end
		if (result.byte_index !== want.idx) begin
			$display("%0t: byte_index expected %0d actual %0d", $time, want.idx, result.byte_index);
			errs++;
		end
		if (result.last !== want.last) begin
			$display("%0t: last expected %0d actual %0d", $time, want.last, result.last);
			errs++;
		end
		if (result.status !== want.status) begin
			$display("%0t: status expected %0d actual %0d", $time, want.status, result.status);
			errs++;
		end
		return errs;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_val = SYNC_RESET;
			max_len  = MAXLEN_RESET;
			framing  = 1'b0;
			ph       = PH_LEN;
			flen     = '0;
			rcv      = '0;
			sum      = '0;
			frame_results_q.delete();
			fails   <= 0;
			pending <= 0;
		end else begin
			// a byte taken at the same edge as a register write still sees the old value
			if (rx.valid && rx.ready)
				take_byte(rx.rx_byte);
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_SYNC)
					sync_val = cfg.data;
				else
					max_len = cfg.data[LEN_W-1:0];
			end
			if (result.valid && result.ready)
				fails <= fails + check_result();
			pending <= frame_results_q.size();
		end
	end

endmodule

FILE: bench/length_framed_checksum_deframer_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// length_framed_checksum_deframer_top_test
// feeds directed and random byte streams of good, corrupted and rejected
// frames through the deframer under several sync and max length settings,
// with bursty input, a stalling result side and one long result hold-off
// ----------------------------------------------------------------------------
module length_framed_checksum_deframer_top_test;
	import lfcd_pkg::*;

	typedef enum {FR_GOOD, FR_BADSUM, FR_BADLEN, FR_NOISE} frame_kind_t;
	typedef enum {RM_OPEN, RM_RANDOM, RM_SPARSE, RM_PERIODIC} ready_mode_t;

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	bit   want_hold;

	logic [DATA_W-1:0] cur_sync;
	logic [LEN_W-1:0]  cur_max;
	int                burst_left;

	lfcd_rx_if  rx_ch ();
	lfcd_cfg_if cfg_ch ();
	lfcd_res_if res_ch ();

	length_framed_checksum_deframer_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.cfg    (cfg_ch),
		.result (res_ch)
	);

	deframer_result_check result_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.cfg     (cfg_ch),
		.result  (res_ch),
		.fails   (fails),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("length_framed_checksum_deframer_top test failed");
		$finish;
	end

	// result side: changing stall patterns, plus one long hold-off on request
	initial begin : receiver
		ready_mode_t mode;
		int          mode_left;
		int          hold_left;
		int          tick;
		bit          hold_seen;
		mode         = RM_OPEN;
		mode_left    = 0;
		hold_left    = 0;
		tick         = 0;
		hold_seen    = 1'b0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (want_hold && !hold_seen) begin
				hold_seen = 1'b1;
				hold_left = 400;
			end
			if (mode_left == 0) begin
				mode      = ready_mode_t'($urandom_range(3));
				mode_left = $urandom_range(200, 20);
			end
			mode_left--;
			tick++;
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				case (mode)
					RM_OPEN:     res_ch.ready <= 1'b1;
					RM_RANDOM:   res_ch.ready <= 1'($urandom_range(1));
					RM_SPARSE:   res_ch.ready <= ($urandom_range(3) == 0);
					default:     res_ch.ready <= (tick % 3 != 0);
				endcase
			end
		end
	end

	task automatic send_byte(input logic [DATA_W-1:0] b);
		int gap;
		@(negedge clk);
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
			repeat (gap) begin
				@(negedge clk);
				rx_ch.valid <= 1'b0;
			end
			burst_left = $urandom_range(24, 1);
		end
	endtask

	// receive side quiet and every expected result drained
	task automatic settle();
		@(negedge clk);
		rx_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		if (idx == CFG_SYNC)
			cur_sync = value;
		else
			cur_max = value[LEN_W-1:0];
	endtask

	function automatic int pick_len();
		int r;
		int small_cap;
		r         = $urandom_range(99);
		small_cap = (cur_max < 6) ? cur_max : 6;
		if (r < 80)
			return $urandom_range(small_cap);
		else if (r < 95)
			return $urandom_range(cur_max);
		return cur_max;
	endfunction

	task automatic send_frame(output int n);
		frame_kind_t       kind;
		int                r;
		int                len;
		logic [DATA_W-1:0] sum;
		logic [DATA_W-1:0] d;
		r = $urandom_range(99);
		if (r < 70)
			kind = FR_GOOD;
		else if (r < 82)
			kind = FR_BADSUM;
		else if (r < 92)
			kind = FR_BADLEN;
		else
			kind = FR_NOISE;
		n = 0;
		case (kind)
			FR_NOISE: begin
				// noise never opens a frame, so no frame is left open at a register write
				repeat ($urandom_range(4, 1)) begin
					d = DATA_W'($urandom_range(255));
					if (d == cur_sync)
						d = ~d;
					send_byte(d);
					n++;
				end
			end
			FR_BADLEN: begin
				len = ($urandom_range(1) == 0) ? int'(cur_max) + 1 :
					$urandom_range(255, int'(cur_max) + 1);
				send_byte(cur_sync);
				send_byte(DATA_W'(len));
				n = 2;
			end
			default: begin
				len = pick_len();
				sum = cur_sync + DATA_W'(len);
				send_byte(cur_sync);
				send_byte(DATA_W'(len));
				for (int i = 0; i < len; i++) begin
					d   = DATA_W'($urandom_range(255));
					sum = sum + d;
					send_byte(d);
				end
				if (kind == FR_BADSUM)
					sum = sum + DATA_W'($urandom_range(255, 1));
				send_byte(sum);
				n = len + 3;
			end
		endcase
	endtask

	task automatic run_phase(input logic [DATA_W-1:0] sync_v, input logic [LEN_W-1:0] max_v,
			input int items, input bit hold);
		int count;
		int n;
		settle();
		write_reg(CFG_SYNC, sync_v);
		write_reg(CFG_MAXLEN, max_v);
		if (hold)
			want_hold = 1'b1;
		count = 0;
		while (count < items) begin
			send_frame(n);
			count += n;
		end
	endtask

	logic [DATA_W-1:0] directed_bytes [25] = '{
		8'h00, 8'hff,                      // noise while hunting
		8'h61, 8'h00, 8'h61,               // empty frame
		8'h61, 8'h01, 8'hff, 8'h61,        // one byte payload
		8'h61, 8'h40,                      // length beyond store
		8'h61, 8'hff,                      // largest length byte
		8'h61, 8'h61,                      // length equal to sync, rejected
		8'h61, 8'h02, 8'h61, 8'h00, 8'hc3, // sync as data, bad checksum
		8'h61, 8'h02, 8'h80, 8'h7f, 8'h62  // two byte payload
	};

	initial begin : stimulus
		arst_n         = 1'b0;
		want_hold      = 1'b0;
		rx_ch.valid    = 1'b0;
		rx_ch.rx_byte  = '0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = CFG_SYNC;
		cfg_ch.data    = '0;
		cur_sync       = SYNC_RESET;
		cur_max        = MAXLEN_RESET;
		burst_left     = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_bytes[i])
			send_byte(directed_bytes[i]);

		run_phase(8'h00, 6'd0, 40, 1'b0);
		run_phase(8'hff, 6'd63, 100, 1'b1);
		run_phase(DATA_W'($urandom_range(255)), LEN_W'($urandom_range(62, 1)), 80, 1'b0);
		run_phase(DATA_W'($urandom_range(255)), 6'd1, 40, 1'b0);
		run_phase(SYNC_RESET, MAXLEN_RESET, 120, 1'b0);

		@(negedge clk);
		rx_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("length_framed_checksum_deframer_top test passed");
		else
			$display("length_framed_checksum_deframer_top test failed");
		$finish;
	end

endmodule
